>>> hw/rtl/char_lcd_number_formatter_assert.svh
// Assertion macros used by the checker file cln_checker.sv.
`ifndef CHAR_LCD_NUMBER_FORMATTER_ASSERT_SVH
`define CHAR_LCD_NUMBER_FORMATTER_ASSERT_SVH

// Checked only while out of reset.
`define CLN_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked on every edge, reset included.
`define CLN_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> hw/rtl/cln_pkg.sv
`default_nettype none

package cln_pkg;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] number;
    logic [4:0]  digit_count;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  localparam logic [2:0] CMD_UDEC = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_HEX  = 3'd2;
  localparam logic [2:0] CMD_BIN  = 3'd3;
  localparam logic [2:0] CMD_CHAR = 3'd4;

  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_LINE2_OFS = 8'h40;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  localparam logic [4:0] MAX_DEC = 5'd5;
  localparam logic [4:0] MAX_HEX = 5'd4;
  localparam logic [4:0] MAX_BIN = 5'd16;

  // Five BCD digits hold any 16-bit value.
  localparam int BCD_DIGITS = 5;
  localparam int BCD_BITS   = 4 * BCD_DIGITS;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = ASCII_ZERO + {4'b0, d};
    end else begin
      r = ASCII_A + {4'b0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cln_bcd_conv.sv
`default_nettype none

// Bit-serial binary to BCD (shift and add-3), one value bit per cycle.
module cln_bcd_conv #(
  parameter int NUMBER_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [NUMBER_WIDTH-1:0]         value,
  output logic                                 busy,
  output logic [cln_pkg::BCD_BITS-1:0]         bcd
);
  import cln_pkg::*;

  localparam int CW = $clog2(NUMBER_WIDTH + 1);

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [NUMBER_WIDTH-1:0] sh_r, sh_nxt;
  logic [BCD_BITS-1:0]     bcd_r, bcd_nxt;
  logic [BCD_BITS-1:0]     adj;

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    sh_nxt  = sh_r;
    bcd_nxt = bcd_r;
    if (start) begin
      cnt_nxt = CW'(NUMBER_WIDTH);
      sh_nxt  = value;
      bcd_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      sh_nxt  = {sh_r[NUMBER_WIDTH-2:0], 1'b0};
      bcd_nxt = {adj[BCD_BITS-2:0], sh_r[NUMBER_WIDTH-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy = (cnt_r != '0);
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

>>> hw/rtl/char_lcd_number_formatter.sv
`default_nettype none

// Channel   Direction  Payload                            Handshake
// in_       input      in_item_t (command .. char_code)   in_valid / in_ready
// out_      output     out_item_t (lcd_byte/is_data/last) out_valid / out_ready
//
// One item at a time: in_ready is high only while the sequencer is idle.
// After an item is accepted, decimal modes first pass the value through the
// bit-serial BCD converter; then one byte per cycle while out_ready is high.
// The output register lets the next item be accepted while the last byte waits.
// Reset (rst_n low, synchronous) empties the output register and idles the block.
module char_lcd_number_formatter #(
  parameter int NUMBER_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cln_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cln_pkg::out_item_t      out_data
);
  import cln_pkg::*;

  localparam int NW = NUMBER_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          cmd_r, cmd_nxt;
  logic [1:0]          line_r, line_nxt;
  logic [4:0]          col_r, col_nxt;
  logic [7:0]          chr_r, chr_nxt;
  logic                neg_r, neg_nxt;
  logic [NW-1:0]       val_r, val_nxt;
  logic [4:0]          dig_left_r, dig_left_nxt;
  logic                pend_cur_r, pend_cur_nxt;
  logic                pend_sign_r, pend_sign_nxt;
  logic                pend_char_r, pend_char_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [31:0]         n32;
  logic [NW-1:0]       num_w;
  logic                in_neg;
  logic [NW-1:0]       in_mag;
  logic [4:0]          in_cnt;
  logic                accept;
  logic                conv_start;
  logic                conv_busy;
  logic [BCD_BITS-1:0] bcd;

  logic [31:0]         v32;
  logic [4:0]          idx;
  logic [3:0]          dig;
  logic [7:0]          cur_byte;
  logic                slot_free;
  logic                have_more;

  assign accept = in_valid && in_ready;
  assign n32    = {16'b0, in_data.number};
  assign num_w  = n32[NW-1:0];
  assign in_neg = (in_data.command == CMD_SDEC) && num_w[NW-1];
  assign in_mag = in_neg ? (~num_w + NW'(1)) : num_w;
  assign conv_start = accept &&
                      (in_data.command == CMD_UDEC || in_data.command == CMD_SDEC);

  always_comb begin
    case (in_data.command) inside
      CMD_UDEC, CMD_SDEC: in_cnt = (in_data.digit_count > MAX_DEC) ? MAX_DEC
                                                                 : in_data.digit_count;
      CMD_HEX:            in_cnt = (in_data.digit_count > MAX_HEX) ? MAX_HEX
                                                                 : in_data.digit_count;
      CMD_BIN:            in_cnt = (in_data.digit_count > MAX_BIN) ? MAX_BIN
                                                                 : in_data.digit_count;
      default:            in_cnt = 5'd0;
    endcase
  end

  cln_bcd_conv #(
    .NUMBER_WIDTH(NW)
  ) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (in_mag),
    .busy  (conv_busy),
    .bcd   (bcd)
  );

  // Digit pick, most significant first
  always_comb begin
    v32 = '0;
    v32[NW-1:0] = val_r;
  end

  assign idx = dig_left_r - 5'd1;

  always_comb begin
    case (cmd_r) inside
      CMD_UDEC, CMD_SDEC: begin
        case (idx[2:0])
          3'd0:    dig = bcd[3:0];
          3'd1:    dig = bcd[7:4];
          3'd2:    dig = bcd[11:8];
          3'd3:    dig = bcd[15:12];
          3'd4:    dig = bcd[19:16];
          default: dig = 4'd0;
        endcase
      end
      CMD_HEX: dig = v32[{idx[1:0], 2'b00} +: 4];
      default: dig = {3'b0, v32[idx[3:0]]};
    endcase
  end

  // Wraps modulo 256, as for out-of-range columns
  assign cur_byte = LCD_SET_DDRAM |
                    (({3'b0, col_r} - 8'd1) + ((line_r == LINE_TWO) ? LCD_LINE2_OFS : 8'd0));

  assign slot_free = !out_valid_r || out_ready;
  assign have_more = pend_cur_r || pend_sign_r || (dig_left_r != 5'd0) || pend_char_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    line_nxt      = line_r;
    col_nxt       = col_r;
    chr_nxt       = chr_r;
    neg_nxt       = neg_r;
    val_nxt       = val_r;
    dig_left_nxt  = dig_left_r;
    pend_cur_nxt  = pend_cur_r;
    pend_sign_nxt = pend_sign_r;
    pend_char_nxt = pend_char_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_data.command;
          line_nxt      = in_data.line;
          col_nxt       = in_data.column;
          chr_nxt       = in_data.char_code;
          neg_nxt       = in_neg;
          val_nxt       = in_mag;
          dig_left_nxt  = in_cnt;
          pend_cur_nxt  = (in_data.line == LINE_ONE) || (in_data.line == LINE_TWO);
          pend_sign_nxt = (in_data.command == CMD_SDEC);
          pend_char_nxt = (in_data.command == CMD_CHAR);
          state_nxt     = conv_start ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!have_more) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pend_cur_r) begin
            pend_cur_nxt         = 1'b0;
            out_data_nxt.lcd_byte = cur_byte;
            out_data_nxt.is_data  = 1'b0;
            out_data_nxt.last     = !pend_sign_r && (dig_left_r == 5'd0) && !pend_char_r;
          end else if (pend_sign_r) begin
            pend_sign_nxt         = 1'b0;
            out_data_nxt.lcd_byte = neg_r ? ASCII_MINUS : ASCII_PLUS;
            out_data_nxt.is_data  = 1'b1;
            out_data_nxt.last     = (dig_left_r == 5'd0);
          end else if (dig_left_r != 5'd0) begin
            dig_left_nxt          = dig_left_r - 5'd1;
            out_data_nxt.lcd_byte = digit_ascii(dig);
            out_data_nxt.is_data  = 1'b1;
            out_data_nxt.last     = (dig_left_r == 5'd1);
          end else begin
            pend_char_nxt         = 1'b0;
            out_data_nxt.lcd_byte = chr_r;
            out_data_nxt.is_data  = 1'b1;
            out_data_nxt.last     = 1'b1;
          end
          if (out_data_nxt.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_cur_r  <= 1'b0;
      pend_sign_r <= 1'b0;
      pend_char_r <= 1'b0;
      dig_left_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_cur_r  <= pend_cur_nxt;
      pend_sign_r <= pend_sign_nxt;
      pend_char_r <= pend_char_nxt;
      dig_left_r  <= dig_left_nxt;
    end
    cmd_r      <= cmd_nxt;
    line_r     <= line_nxt;
    col_r      <= col_nxt;
    chr_r      <= chr_nxt;
    neg_r      <= neg_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/cln_checker.sv
`default_nettype none

`include "char_lcd_number_formatter_assert.svh"

module cln_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire cln_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire cln_pkg::out_item_t out_data
);
  import cln_pkg::*;

  `CLN_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

  `CLN_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled item changed")

  `CLN_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data), "waiting input item changed")

  `CLN_ASSERT(a_one_at_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "accepted while busy")

  `CLN_ASSERT(a_cmd_is_addr, clk, rst_n, out_valid && !out_data.is_data |-> out_data.lcd_byte[7], "command byte without set-address bit")

endmodule

bind char_lcd_number_formatter cln_checker u_cln_checker (.*);

`default_nettype wire

>>> tb/tb_char_lcd_number_formatter.sv
`default_nettype none

module tb_char_lcd_number_formatter;
  timeunit 1ns;
  timeprecision 1ps;

  import cln_pkg::*;

  // Commands and lines that the package leaves unnamed.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;
  localparam logic [1:0] LINE_NONE  = 2'd0;
  localparam logic [1:0] LINE_THREE = 2'd3;

  localparam int RANDOM_REQUESTS = 480;
  localparam int HOLD_OFF_CYCLES = 400;

  class lcd_stream_board;
    out_item_t pending_bytes[$];
    out_item_t request_bytes[$];
    int errors;
    int requests;
    int silent_requests;
    int bytes_checked;
    int cmd_count[8];

    function void add_byte(logic [7:0] value, logic data_flag);
      out_item_t b;
      b.lcd_byte = value;
      b.is_data  = data_flag;
      b.last     = 1'b0;
      request_bytes.push_back(b);
    endfunction

    // Digits most significant first; positions past the value come out '0'.
    function void add_digits(longint unsigned value, int count, longint unsigned radix);
      longint unsigned weight;
      longint unsigned digit;
      for (int i = count; i > 0; i--) begin
        weight = 1;
        for (int j = 1; j < i; j++) weight = weight * radix;
        digit = (value / weight) % radix;
        if (digit < 10) add_byte(ASCII_ZERO + 8'(digit), 1'b1);
        else add_byte(ASCII_A + 8'(digit - 10), 1'b1);
      end
    endfunction

    function int clamp_count(logic [4:0] asked, logic [4:0] limit);
      return (asked > limit) ? int'(limit) : int'(asked);
    endfunction

    function void note_request(in_item_t req);
      logic [7:0]  cursor;
      logic [15:0] magnitude;
      out_item_t   tail;
      request_bytes.delete();
      requests++;
      cmd_count[req.command]++;
      // address wraps modulo 256, so column 0 lands on 0xFF / 0xBF
      cursor = 8'(req.column) - 8'd1;
      if (req.line == LINE_ONE) begin
        add_byte(LCD_SET_DDRAM | cursor, 1'b0);
      end else if (req.line == LINE_TWO) begin
        add_byte(LCD_SET_DDRAM | (cursor + LCD_LINE2_OFS), 1'b0);
      end
      case (req.command)
        CMD_UDEC: add_digits(req.number, clamp_count(req.digit_count, MAX_DEC), 10);
        CMD_SDEC: begin
          magnitude = req.number[15] ? -req.number : req.number;
          add_byte(req.number[15] ? ASCII_MINUS : ASCII_PLUS, 1'b1);
          add_digits(magnitude, clamp_count(req.digit_count, MAX_DEC), 10);
        end
        CMD_HEX: add_digits(req.number, clamp_count(req.digit_count, MAX_HEX), 16);
        CMD_BIN: add_digits(req.number, clamp_count(req.digit_count, MAX_BIN), 2);
        CMD_CHAR: add_byte(req.char_code, 1'b1);
        default: ;
      endcase
      if (request_bytes.size() == 0) begin
        silent_requests++;
      end else begin
        tail = request_bytes.pop_back();
        tail.last = 1'b1;
        request_bytes.push_back(tail);
      end
      foreach (request_bytes[k]) pending_bytes.push_back(request_bytes[k]);
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual byte=%h is_data=%b last=%b",
                 $time, got.lcd_byte, got.is_data, got.last);
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (got.lcd_byte !== want.lcd_byte) begin
        errors++;
        $display("%0t: lcd_byte mismatch: expected %h, actual %h",
                 $time, want.lcd_byte, got.lcd_byte);
      end
      if (got.is_data !== want.is_data) begin
        errors++;
        $display("%0t: is_data mismatch: expected %b, actual %b",
                 $time, want.is_data, got.is_data);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  bit hold_off = 1'b0;
  bit calm = 1'b0;

  lcd_stream_board board = new();

  always #5 clk = ~clk;

  char_lcd_number_formatter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_request(in_data);
    if (rst_n && out_valid && out_ready) board.check_byte(out_data);
  end

  function automatic in_item_t make_request(logic [2:0] cmd, logic [1:0] ln, logic [4:0] col,
                                            logic [15:0] num, logic [4:0] cnt,
                                            logic [7:0] chr);
    in_item_t r;
    r.command     = cmd;
    r.line        = ln;
    r.column      = col;
    r.number      = num;
    r.digit_count = cnt;
    r.char_code   = chr;
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t   r;
    logic [4:0] cap;
    if ($urandom_range(0, 99) < 15) begin
      // noise: any value the fields can hold
      r.command     = 3'($urandom_range(0, 7));
      r.line        = 2'($urandom_range(0, 3));
      r.column      = 5'($urandom_range(0, 31));
      r.number      = 16'($urandom_range(0, 65535));
      r.digit_count = 5'($urandom_range(0, 31));
      r.char_code   = 8'($urandom_range(0, 255));
    end else begin
      r.command = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) r.line = $urandom_range(0, 1) ? LINE_THREE : LINE_NONE;
      else r.line = $urandom_range(0, 1) ? LINE_TWO : LINE_ONE;
      r.column = 5'($urandom_range(1, 16));
      case (r.command)
        CMD_HEX: cap = MAX_HEX;
        CMD_BIN: cap = MAX_BIN;
        default: cap = MAX_DEC;
      endcase
      r.digit_count = 5'($urandom_range(0, cap));
      case ($urandom_range(0, 7))
        0: r.number = 16'h0000;
        1: r.number = 16'hFFFF;
        2: r.number = 16'h8000;
        3: r.number = 16'h7FFF;
        default: r.number = 16'($urandom_range(0, 65535));
      endcase
      r.char_code = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  // Offers one item and returns at the edge where it is taken.
  task automatic send_request(input in_item_t req, input int idle_pct);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        // long stall: the block fills and backs up its input
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    in_item_t opening[$];
    in_item_t req;
    int useful;
    int sent;
    int idle_pct;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    opening.push_back(make_request(CMD_UDEC, LINE_ONE, 5'd1, 16'd0, 5'd5, 8'h00));
    opening.push_back(make_request(CMD_UDEC, LINE_TWO, 5'd16, 16'hFFFF, 5'd5, 8'hFF));
    opening.push_back(make_request(CMD_UDEC, LINE_ONE, 5'd5, 16'd12345, 5'd3, 8'h00));
    opening.push_back(make_request(CMD_UDEC, LINE_TWO, 5'd1, 16'd999, 5'd0, 8'h00));
    opening.push_back(make_request(CMD_UDEC, LINE_ONE, 5'd2, 16'd54321, 5'd31, 8'h00));
    opening.push_back(make_request(CMD_SDEC, LINE_ONE, 5'd1, 16'h8000, 5'd5, 8'h00));
    opening.push_back(make_request(CMD_SDEC, LINE_TWO, 5'd3, 16'h7FFF, 5'd5, 8'h00));
    opening.push_back(make_request(CMD_SDEC, LINE_ONE, 5'd1, 16'hFFFF, 5'd16, 8'h00));
    opening.push_back(make_request(CMD_SDEC, LINE_TWO, 5'd9, 16'd1234, 5'd0, 8'h00));
    opening.push_back(make_request(CMD_HEX, LINE_ONE, 5'd1, 16'hFFFF, 5'd4, 8'h00));
    opening.push_back(make_request(CMD_HEX, LINE_TWO, 5'd13, 16'hA5C3, 5'd31, 8'h00));
    opening.push_back(make_request(CMD_HEX, LINE_ONE, 5'd7, 16'h0000, 5'd2, 8'h00));
    opening.push_back(make_request(CMD_BIN, LINE_ONE, 5'd1, 16'hFFFF, 5'd16, 8'h00));
    opening.push_back(make_request(CMD_BIN, LINE_TWO, 5'd1, 16'h8001, 5'd31, 8'h00));
    opening.push_back(make_request(CMD_BIN, LINE_NONE, 5'd1, 16'h5555, 5'd5, 8'h00));
    opening.push_back(make_request(CMD_CHAR, LINE_ONE, 5'd16, 16'd1234, 5'd9, 8'h00));
    opening.push_back(make_request(CMD_CHAR, LINE_TWO, 5'd1, 16'hFFFF, 5'd31, 8'hFF));
    opening.push_back(make_request(CMD_CHAR, LINE_THREE, 5'd4, 16'h0000, 5'd0, 8'h41));
    opening.push_back(make_request(CMD_UDEC, LINE_ONE, 5'd0, 16'd42, 5'd2, 8'h00));
    opening.push_back(make_request(CMD_HEX, LINE_TWO, 5'd0, 16'hBEEF, 5'd4, 8'h00));
    opening.push_back(make_request(CMD_UDEC, LINE_TWO, 5'd31, 16'd7, 5'd1, 8'h00));
    opening.push_back(make_request(CMD_SDEC, LINE_ONE, 5'd17, 16'd5, 5'd2, 8'h00));
    opening.push_back(make_request(CMD_RSVD_5, LINE_ONE, 5'd3, 16'hFFFF, 5'd5, 8'hFF));
    opening.push_back(make_request(CMD_RSVD_7, LINE_TWO, 5'd31, 16'h1234, 5'd4, 8'h55));
    opening.push_back(make_request(CMD_RSVD_6, LINE_NONE, 5'd8, 16'h0F0F, 5'd3, 8'hAA));
    foreach (opening[k]) send_request(opening[k], 30);

    useful = 0;
    sent = 0;
    idle_pct = 0;
    while (useful < RANDOM_REQUESTS) begin
      if (sent % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 25;
          default: idle_pct = 60;
        endcase
      end
      if (sent == 200) hold_off = 1'b1;
      if (useful >= RANDOM_REQUESTS - 60) calm = 1'b1;
      req = random_request();
      send_request(req, calm ? 0 : idle_pct);
      if (req.line == LINE_ONE || req.line == LINE_TWO || req.command <= CMD_CHAR) useful++;
      sent++;
    end
    in_valid <= 1'b0;

    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d requests (%0d gave no bytes), %0d bytes checked, one long output stall",
             board.requests, board.silent_requests, board.bytes_checked);
    $display("per command: udec %0d sdec %0d hex %0d bin %0d char %0d reserved %0d",
             board.cmd_count[CMD_UDEC], board.cmd_count[CMD_SDEC], board.cmd_count[CMD_HEX],
             board.cmd_count[CMD_BIN], board.cmd_count[CMD_CHAR],
             board.cmd_count[CMD_RSVD_5] + board.cmd_count[CMD_RSVD_6]
               + board.cmd_count[CMD_RSVD_7]);
    if (board.errors == 0) begin
      $display("tb_char_lcd_number_formatter: clean");
    end else begin
      $display("tb_char_lcd_number_formatter: errors");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("timeout with %0d bytes still expected", board.pending_bytes.size());
    $display("tb_char_lcd_number_formatter: errors");
    $finish;
  end

endmodule

`default_nettype wire
